// ----- sv/led_pattern_sequencer_unit_assert.svh -----
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef LED_PATTERN_SEQUENCER_UNIT_ASSERT_SVH
`define LED_PATTERN_SEQUENCER_UNIT_ASSERT_SVH

// condition holds at every edge
`define LDPS_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("ldps check failed");

// consequent holds in the same cycle as the antecedent
`define LDPS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ldps check failed");

// consequent holds in the cycle after the antecedent
`define LDPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ldps check failed");

`endif

// ----- sv/ldps_pkg.sv -----
package ldps_pkg;

	localparam int LED_W      = 8;
	localparam int MODE_W     = 4;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [LED_W-1:0] SEED_RESET = 8'd115;
	localparam logic [LED_W-1:0] LCG_MUL    = 8'd251;
	localparam logic [LED_W-1:0] LCG_ADD    = 8'd37;

	// pattern codes
	localparam logic [MODE_W-1:0] MODE_NONE      = 4'd0;
	localparam logic [MODE_W-1:0] MODE_BIN_UP    = 4'd1;
	localparam logic [MODE_W-1:0] MODE_BIN_DOWN  = 4'd2;
	localparam logic [MODE_W-1:0] MODE_GRAY_UP   = 4'd3;
	localparam logic [MODE_W-1:0] MODE_GRAY_DOWN = 4'd4;
	localparam logic [MODE_W-1:0] MODE_BCD_UP    = 4'd5;
	localparam logic [MODE_W-1:0] MODE_BCD_DOWN  = 4'd6;
	localparam logic [MODE_W-1:0] MODE_SNAKE     = 4'd7;
	localparam logic [MODE_W-1:0] MODE_STACK     = 4'd8;
	localparam logic [MODE_W-1:0] MODE_RANDOM    = 4'd9;

	// register index of the seed within the config space
	localparam logic REG_SEED = 1'b0;

	typedef struct packed {
		logic next_b;
		logic prev_b;
		logic stop_b;
	} btn_t;

endpackage

// ----- sv/ldps_apb.sv -----
module ldps_apb
	import ldps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [LED_W-1:0]      seed
);

	logic [LED_W-1:0] seed_q;
	logic             hit;

	// word index is the bit above the byte offset
	assign hit    = (paddr[CFG_ADDR_W-1] == REG_SEED);
	assign pready = 1'b1;
	assign seed   = seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (psel && penable && pwrite && hit) begin
			seed_q <= pwdata[LED_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(CFG_DATA_W-LED_W){1'b0}}, seed_q};
		end
	end

endmodule

// ----- sv/ldps_engine.sv -----
`include "led_pattern_sequencer_unit_assert.svh"

module ldps_engine
	import ldps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  btn_t              btn,
	input  logic [LED_W-1:0]  seed,
	output logic [LED_W-1:0]  led,
	output logic              busy,
	output logic [MODE_W-1:0] mode
);

	logic [MODE_W-1:0] mode_q, mode_d;
	logic              busy_q, busy_d;
	logic [7:0]        step_q, step_d;
	logic [2:0]        col_q, col_d;
	logic [7:0]        base_q, base_d;
	logic [1:0]        dwell_q, dwell_d;
	logic [7:0]        rand_q, rand_d;
	logic [7:0]        led_q, led_d;

	logic [MODE_W-1:0] sel_mode;
	logic [2:0]        frame_len;
	logic              frame_end;
	logic              go_on;
	logic              col_last;
	logic [7:0]        adv_step;
	logic [2:0]        adv_col;
	logic [7:0]        adv_base;
	logic [7:0]        adv_rand;
	logic [15:0]       lcg_prod;

	function automatic logic [7:0] gray8(input logic [7:0] v);
		return v ^ (v >> 1);
	endfunction

	// tens by reciprocal multiply, exact for v below 179
	function automatic logic [7:0] bcd8(input logic [6:0] v);
		logic [13:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		prod = {7'd0, v} * 14'd103;
		tens = prod[13:10];
		ones = v - ({3'd0, tens} * 7'd10);
		return {tens, ones[3:0]};
	endfunction

	function automatic logic [7:0] frame_value(
		input logic [MODE_W-1:0] m,
		input logic [7:0]        s,
		input logic [7:0]        base,
		input logic [7:0]        rnd,
		input logic [7:0]        keep
	);
		logic [6:0]  clamp;
		logic [3:0]  e;
		logic [10:0] snake;
		logic [7:0]  r;
		clamp = (s > 8'd99) ? 7'd99 : s[6:0];
		if (s <= 8'd5) begin
			e = s[3:0];
		end else if (s <= 8'd10) begin
			e = 4'd10 - s[3:0];
		end else begin
			e = 4'd0;
		end
		snake = 11'd7 << e;
		unique case (m)
			MODE_BIN_UP:    r = s;
			MODE_BIN_DOWN:  r = ~s;
			MODE_GRAY_UP:   r = gray8(s);
			MODE_GRAY_DOWN: r = gray8(~s);
			MODE_BCD_UP:    r = bcd8(clamp);
			MODE_BCD_DOWN:  r = bcd8((s > 8'd99) ? 7'd0 : 7'd99 - s[6:0]);
			MODE_SNAKE:     r = snake[7:0];
			MODE_STACK:     r = base + (8'd1 << s[2:0]);
			MODE_RANDOM:    r = rnd;
			default:        r = keep;
		endcase
		return r;
	endfunction

	// mode selection while idle, next wins over prev
	always_comb begin
		if (btn.next_b) begin
			sel_mode = (mode_q < MODE_RANDOM) ? mode_q + 4'd1 : MODE_NONE;
		end else begin
			sel_mode = (mode_q > MODE_NONE && mode_q <= MODE_RANDOM) ?
				mode_q - 4'd1 : MODE_RANDOM;
		end
	end

	always_comb begin
		unique case (mode_q)
			MODE_SNAKE:  frame_len = 3'd2;
			MODE_RANDOM: frame_len = 3'd4;
			default:     frame_len = 3'd1;
		endcase
	end

	assign frame_end = ({1'b0, dwell_q} + 3'd1) >= frame_len;
	assign col_last  = (col_q >= 3'd6) || (step_q >= (8'd6 - {5'd0, col_q}));
	assign lcg_prod  = rand_q * LCG_MUL;

	// end-of-frame step of the running pattern
	always_comb begin
		go_on    = 1'b0;
		adv_step = step_q;
		adv_col  = col_q;
		adv_base = base_q;
		adv_rand = rand_q;
		unique case (mode_q)
			MODE_BIN_UP, MODE_BIN_DOWN, MODE_GRAY_UP, MODE_GRAY_DOWN: begin
				go_on    = !btn.stop_b && (step_q != 8'd255);
				adv_step = step_q + 8'd1;
			end
			MODE_BCD_UP, MODE_BCD_DOWN: begin
				go_on    = !btn.stop_b && (step_q < 8'd99);
				adv_step = step_q + 8'd1;
			end
			MODE_SNAKE: begin
				go_on    = !btn.stop_b && (step_q < 8'd10);
				adv_step = step_q + 8'd1;
			end
			MODE_STACK: begin
				if (col_last) begin
					// walking bit settles onto the base, next column starts
					go_on    = !btn.stop_b && (col_q < 3'd6);
					adv_base = base_q + (8'd1 << step_q[2:0]);
					adv_col  = col_q + 3'd1;
					adv_step = 8'd0;
				end else begin
					go_on    = 1'b1;
					adv_step = step_q + 8'd1;
				end
			end
			MODE_RANDOM: begin
				go_on    = !btn.stop_b;
				adv_rand = lcg_prod[7:0] + LCG_ADD;
			end
			default: go_on = 1'b0;
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		busy_d  = busy_q;
		step_d  = step_q;
		col_d   = col_q;
		base_d  = base_q;
		dwell_d = dwell_q;
		rand_d  = rand_q;
		led_d   = led_q;
		if (busy_q) begin
			if (frame_end) begin
				if (go_on) begin
					step_d = adv_step;
					col_d  = adv_col;
					base_d = adv_base;
					rand_d = adv_rand;
					led_d  = frame_value(mode_q, adv_step, adv_base, adv_rand, led_q);
				end else begin
					busy_d = 1'b0;
				end
				dwell_d = 2'd0;
			end else begin
				dwell_d = dwell_q + 2'd1;
			end
		end else if (btn.next_b || btn.prev_b) begin
			mode_d = sel_mode;
			if (sel_mode != MODE_NONE) begin
				busy_d  = 1'b1;
				step_d  = 8'd0;
				col_d   = 3'd0;
				base_d  = 8'd0;
				dwell_d = 2'd0;
				rand_d  = seed;
				led_d   = frame_value(sel_mode, 8'd0, 8'd0, seed, led_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NONE;
			busy_q  <= 1'b0;
			step_q  <= '0;
			col_q   <= '0;
			base_q  <= '0;
			dwell_q <= '0;
			rand_q  <= SEED_RESET;
			led_q   <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			busy_q  <= busy_d;
			step_q  <= step_d;
			col_q   <= col_d;
			base_q  <= base_d;
			dwell_q <= dwell_d;
			rand_q  <= rand_d;
			led_q   <= led_d;
		end
	end

	assign led  = led_q;
	assign busy = busy_q;
	assign mode = mode_q;

	`LDPS_ASSERT_IMPL(a_busy_has_mode, busy_q, mode_q != MODE_NONE && mode_q <= MODE_RANDOM)
	`LDPS_ASSERT_IMPL(a_dwell_only_long, dwell_q != 2'd0,
		busy_q && (mode_q == MODE_SNAKE || mode_q == MODE_RANDOM))
	`LDPS_ASSERT_ALWAYS(a_col_bound, col_q <= 3'd6)
	`LDPS_ASSERT_NEXT(a_hold_no_beat, !fire,
		$stable(led_q) && $stable(busy_q) && $stable(mode_q))

endmodule

// ----- sv/led_pattern_sequencer_unit.sv -----
// led pattern sequencer
// input channel: one beat per base tick (in_valid/in_stall) carrying the
// next, previous and stop button levels; output channel: one beat per
// input beat (out_valid/out_stall) with the latched leds, running flag and
// selected mode after that tick.
// the seed of the random walk is written over the apb port at address 0;
// a new seed is used at the next start of the random pattern.
// a result passes the input register, then the pattern state which doubles
// as result register; a stalled output can hold it in the input register.
// throughput: one beat per cycle while not stalled; the state update is a
// single pass of logic from the input register into the state registers.
// a stalled output holds its beat; the input register still takes one more
// beat, then in_stall rises until the output drains.
// reset clears mode, leds and running, empties both stages and loads the
// seed with its default; the block is ready right after reset.
module led_pattern_sequencer_unit
	import ldps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  next_button,
	input  logic                  prev_button,
	input  logic                  stop_button,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [LED_W-1:0]      led_value,
	output logic                  running,
	output logic [MODE_W-1:0]     mode,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic             valid_s1;
	btn_t             btn_s1;
	logic             valid_s2;
	logic             out_free;
	logic             adv;
	logic             in_take;
	logic [LED_W-1:0] seed;

	assign out_free = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			btn_s1 <= '{next_b: next_button, prev_b: prev_button, stop_b: stop_button};
		end
	end

	ldps_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.seed    (seed)
	);

	ldps_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.btn    (btn_s1),
		.seed   (seed),
		.led    (led_value),
		.busy   (running),
		.mode   (mode)
	);

	assign out_valid = valid_s2;

endmodule

// ----- dv/tb_led_pattern_sequencer_unit.sv -----
`timescale 1ns / 1ps

module tb_led_pattern_sequencer_unit
	import ldps_pkg::*;
();

	localparam int HALF_PERIOD = 6;
	localparam int SETTLE_CYCLES = 4;
	localparam int IDLE_MAX = 14;
	localparam int RANDOM_PER_PHASE = 100;
	localparam longint LIMIT_NS = 4_000_000;

	typedef enum logic [1:0] {
		ENT_BEAT,
		ENT_SEED,
		ENT_DRAIN
	} entry_kind_t;

	typedef struct {
		entry_kind_t      kind;
		logic             nb;
		logic             pb;
		logic             sb;
		logic [LED_W-1:0] seed;
		int               gap;
		int               rx_wait;
	} stim_entry_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              busy;
		logic [7:0]        step;
		logic [2:0]        col;
		logic [LED_W-1:0]  base;
		logic [1:0]        dwell;
		logic [LED_W-1:0]  rnd;
		logic [LED_W-1:0]  led;
	} led_seq_t;

	typedef struct {
		logic [LED_W-1:0]  led;
		logic              run;
		logic [MODE_W-1:0] mode;
		int                rx_wait;
	} led_frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic next_button = 1'b0;
	logic prev_button = 1'b0;
	logic stop_button = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [LED_W-1:0] led_value;
	logic running;
	logic [MODE_W-1:0] mode;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	led_pattern_sequencer_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.next_button (next_button),
		.prev_button (prev_button),
		.stop_button (stop_button),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.led_value   (led_value),
		.running     (running),
		.mode        (mode),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	stim_entry_t pending_q[$];
	led_frame_t led_frames_q[$];

	// generator-side copy of the sequencer, used to shape sessions
	led_seq_t gen_seq;
	logic [LED_W-1:0] gen_seed = SEED_RESET;
	int idle_max = IDLE_MAX;

	// checker-side copy, advanced on each accepted beat
	led_seq_t chk_seq;
	logic [LED_W-1:0] chk_seed = SEED_RESET;

	int tx_beats = 0;
	int tx_seen = 0;
	int rx_beats = 0;
	int rx_seen = 0;
	int rx_next_wait = 0;
	int rx_left = 0;
	int cfg_writes = 0;
	int cfg_seen = 0;
	int mismatches = 0;
	bit patterns_seen[10];

	stim_entry_t cur;
	bit have_cur = 1'b0;
	int gap_left = 0;
	int settle_left = 0;

	function automatic led_seq_t idle_seq(logic [LED_W-1:0] seed);
		led_seq_t s;
		s = '0;
		s.rnd = seed;
		return s;
	endfunction

	function automatic logic [LED_W-1:0] gray_of(logic [LED_W-1:0] v);
		return v ^ (v >> 1);
	endfunction

	function automatic logic [LED_W-1:0] bcd_of(int v);
		return LED_W'(((v / 10) << 4) | (v % 10));
	endfunction

	function automatic int frame_ticks(logic [MODE_W-1:0] m);
		if (m == MODE_SNAKE)
			return 2;
		if (m == MODE_RANDOM)
			return 4;
		return 1;
	endfunction

	function automatic logic [LED_W-1:0] frame_leds(led_seq_t s);
		int e;
		case (s.mode)
			MODE_BIN_UP:    return s.step;
			MODE_BIN_DOWN:  return 8'd255 - s.step;
			MODE_GRAY_UP:   return gray_of(s.step);
			MODE_GRAY_DOWN: return gray_of(8'd255 - s.step);
			MODE_BCD_UP:    return bcd_of(s.step > 99 ? 99 : int'(s.step));
			MODE_BCD_DOWN:  return bcd_of(s.step > 99 ? 0 : 99 - int'(s.step));
			MODE_SNAKE: begin
				e = (s.step <= 5) ? int'(s.step) : ((s.step <= 10) ? 10 - int'(s.step) : 0);
				return LED_W'(8'd7 << e);
			end
			MODE_STACK:     return s.base + (8'd1 << s.step[2:0]);
			MODE_RANDOM:    return s.rnd;
			default:        return s.led;
		endcase
	endfunction

	// one base tick of the sequencer
	function automatic led_seq_t next_led_state(led_seq_t s, logic nb, logic pb, logic sb,
			logic [LED_W-1:0] seed);
		logic go;
		if (s.busy) begin
			if (int'(s.dwell) + 1 >= frame_ticks(s.mode)) begin
				go = 1'b1;
				case (s.mode)
					MODE_BIN_UP, MODE_BIN_DOWN, MODE_GRAY_UP, MODE_GRAY_DOWN:
						if (sb || s.step == 8'd255)
							go = 1'b0;
						else
							s.step = s.step + 1'b1;
					MODE_BCD_UP, MODE_BCD_DOWN:
						if (sb || s.step >= 99)
							go = 1'b0;
						else
							s.step = s.step + 1'b1;
					MODE_SNAKE:
						if (sb || s.step >= 10)
							go = 1'b0;
						else
							s.step = s.step + 1'b1;
					MODE_STACK: begin
						// stop only counts at the last frame of a column
						if (s.col >= 6 || int'(s.step) >= 6 - int'(s.col)) begin
							if (sb || s.col >= 6) begin
								go = 1'b0;
							end else begin
								s.base = s.base + (8'd1 << s.step[2:0]);
								s.col = s.col + 1'b1;
								s.step = '0;
							end
						end else begin
							s.step = s.step + 1'b1;
						end
					end
					MODE_RANDOM:
						if (sb)
							go = 1'b0;
						else
							s.rnd = s.rnd * LCG_MUL + LCG_ADD;
					default: go = 1'b0;
				endcase
				if (go)
					s.led = frame_leds(s);
				else
					s.busy = 1'b0;
				s.dwell = '0;
			end else begin
				s.dwell = s.dwell + 1'b1;
			end
		end else if (nb || pb) begin
			if (nb)
				s.mode = (s.mode < MODE_RANDOM) ? s.mode + 1'b1 : MODE_NONE;
			else
				s.mode = (s.mode > MODE_NONE && s.mode <= MODE_RANDOM) ? s.mode - 1'b1
					: MODE_RANDOM;
			if (s.mode != MODE_NONE) begin
				s.busy = 1'b1;
				s.step = '0;
				s.col = '0;
				s.base = '0;
				s.dwell = '0;
				s.rnd = seed;
				s.led = frame_leds(s);
			end
		end
		return s;
	endfunction

	task automatic add_beat(logic nb, logic pb, logic sb);
		stim_entry_t t;
		t.kind = ENT_BEAT;
		t.nb = nb;
		t.pb = pb;
		t.sb = sb;
		t.seed = '0;
		t.gap = $urandom_range(0, idle_max);
		t.rx_wait = $urandom_range(0, idle_max);
		pending_q.push_back(t);
		gen_seq = next_led_state(gen_seq, nb, pb, sb, gen_seed);
	endtask

	task automatic add_ctrl(entry_kind_t kind, logic [LED_W-1:0] seed);
		stim_entry_t t;
		t.kind = kind;
		t.nb = 1'b0;
		t.pb = 1'b0;
		t.sb = 1'b0;
		t.seed = seed;
		t.gap = 0;
		t.rx_wait = 0;
		pending_q.push_back(t);
		if (kind == ENT_SEED)
			gen_seed = seed;
	endtask

	// sessions: a press (or a beat with no press) while idle, then a run with
	// ignored button noise and either a stop or the natural end of the pattern
	task automatic add_sessions(int count);
		int made;
		int r;
		int run_ticks;
		int cap;
		bit full;
		logic nb, pb, sb;
		made = 0;
		run_ticks = 0;
		cap = 0;
		full = 1'b0;
		while (made < count) begin
			if (!gen_seq.busy) begin
				r = $urandom_range(0, 9);
				nb = (r < 5) || (r == 8);
				pb = (r >= 5);
				if (r == 9)
					pb = 1'b0;
				sb = ($urandom_range(0, 3) == 0);
				full = ($urandom_range(0, 5) == 0);
				cap = $urandom_range(4, 40);
				run_ticks = 0;
			end else begin
				run_ticks++;
				nb = ($urandom_range(0, 5) == 0);
				pb = ($urandom_range(0, 5) == 0);
				if (full)
					sb = (gen_seq.mode == MODE_RANDOM) && (run_ticks > cap);
				else
					sb = (run_ticks > cap) || ($urandom_range(0, 15) == 0);
			end
			add_beat(nb, pb, sb);
			made++;
		end
	endtask

	initial begin
		forever #(HALF_PERIOD) clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

	// receiver: holds stall for the drawn count after each beat
	always @(negedge clk) begin : sink_drive
		if (arst_n) begin
			if (rx_beats != rx_seen) begin
				rx_seen = rx_beats;
				rx_left = rx_next_wait;
			end
			out_stall <= (rx_left > 0);
			if (rx_left > 0)
				rx_left--;
		end
	end

	always @(negedge clk) begin : stim_drive
		logic nv, ns, ne, nw;
		if (arst_n) begin
			nv = in_valid;
			ns = psel;
			ne = penable;
			nw = pwrite;
			if (tx_beats != tx_seen) begin
				tx_seen = tx_beats;
				nv = 1'b0;
				have_cur = 1'b0;
			end
			if (ne && cfg_writes != cfg_seen) begin
				cfg_seen = cfg_writes;
				ns = 1'b0;
				ne = 1'b0;
				nw = 1'b0;
				have_cur = 1'b0;
			end
			if (!have_cur && pending_q.size() != 0) begin
				cur = pending_q.pop_front();
				have_cur = 1'b1;
				gap_left = cur.gap;
				settle_left = SETTLE_CYCLES;
			end
			if (have_cur && !nv && !ns) begin
				case (cur.kind)
					ENT_BEAT:
						if (gap_left > 0) begin
							gap_left--;
						end else begin
							nv = 1'b1;
							next_button <= cur.nb;
							prev_button <= cur.pb;
							stop_button <= cur.sb;
						end
					default:
						// wait for every result, then let the pipeline settle
						if (led_frames_q.size() == 0) begin
							if (settle_left > 0) begin
								settle_left--;
							end else if (cur.kind == ENT_DRAIN) begin
								have_cur = 1'b0;
							end else begin
								ns = 1'b1;
								nw = 1'b1;
								paddr <= {REG_SEED, 2'b00};
								pwdata <= CFG_DATA_W'(cur.seed);
							end
						end
				endcase
			end else if (ns && !ne) begin
				ne = 1'b1;
			end
			in_valid <= nv;
			psel <= ns;
			penable <= ne;
			pwrite <= nw;
		end
	end

	always @(posedge clk) begin : watch
		led_frame_t want;
		led_seq_t prior;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_SEED, 2'b00})
					chk_seed = pwdata[LED_W-1:0];
				cfg_writes++;
			end
			if (in_valid && !in_stall) begin
				prior = chk_seq;
				chk_seq = next_led_state(chk_seq, next_button, prev_button, stop_button,
					chk_seed);
				if (!prior.busy && chk_seq.busy)
					patterns_seen[chk_seq.mode] = 1'b1;
				want.led = chk_seq.led;
				want.run = chk_seq.busy;
				want.mode = chk_seq.mode;
				want.rx_wait = cur.rx_wait;
				led_frames_q.push_back(want);
				tx_beats++;
			end
			if (out_valid && !out_stall) begin
				if (led_frames_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output beat: leds %h running %b mode %0d",
							led_value, running, mode);
					rx_next_wait = 0;
				end else begin
					want = led_frames_q.pop_front();
					if (led_value !== want.led || running !== want.run
							|| mode !== want.mode) begin
						mismatches++;
						if (mismatches <= 10)
							$display("beat %0d: expected leds %h running %b mode %0d, got leds %h running %b mode %0d",
								rx_beats, want.led, want.run, want.mode,
								led_value, running, mode);
					end
					rx_next_wait = want.rx_wait;
				end
				rx_beats++;
			end
		end
	end

	initial begin : run
		int n_patterns;
		chk_seq = idle_seq(SEED_RESET);
		gen_seq = idle_seq(SEED_RESET);

		// directed: wraps, button priority, ignored stops and buttons
		add_beat(1'b0, 1'b0, 1'b1);
		add_beat(1'b0, 1'b1, 1'b1);
		add_beat(1'b1, 1'b0, 1'b1);
		add_beat(1'b1, 1'b1, 1'b0);
		add_beat(1'b0, 1'b1, 1'b0);
		add_beat(1'b0, 1'b0, 1'b1);
		add_beat(1'b1, 1'b0, 1'b0);
		add_beat(1'b1, 1'b1, 1'b0);
		add_beat(1'b0, 1'b0, 1'b0);
		add_beat(1'b0, 1'b0, 1'b0);
		add_beat(1'b1, 1'b0, 1'b1);
		add_beat(1'b0, 1'b1, 1'b0);
		add_beat(1'b0, 1'b1, 1'b0);
		repeat (4) add_beat(1'b0, 1'b0, 1'b1);
		// stack: stop held through the first column
		add_beat(1'b0, 1'b1, 1'b0);
		repeat (7) add_beat(1'b0, 1'b0, 1'b1);
		// snake: stop at the first frame end ends everything
		add_beat(1'b0, 1'b1, 1'b0);
		repeat (2) add_beat(1'b0, 1'b0, 1'b1);

		add_ctrl(ENT_SEED, 8'd0);
		add_sessions(RANDOM_PER_PHASE);
		add_ctrl(ENT_SEED, 8'd255);
		add_sessions(RANDOM_PER_PHASE / 2);
		add_ctrl(ENT_DRAIN, '0);
		add_sessions(RANDOM_PER_PHASE / 2);
		add_ctrl(ENT_SEED, LED_W'($urandom_range(1, 254)));
		idle_max = 0;
		add_sessions(RANDOM_PER_PHASE);
		idle_max = IDLE_MAX;
		add_ctrl(ENT_SEED, LED_W'($urandom));
		add_sessions(RANDOM_PER_PHASE);
		add_ctrl(ENT_SEED, SEED_RESET);
		add_sessions(RANDOM_PER_PHASE);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || have_cur || in_valid)
			@(posedge clk);
		while (led_frames_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES * 2) @(posedge clk);

		n_patterns = 0;
		for (int m = 1; m < 10; m++)
			if (patterns_seen[m])
				n_patterns++;
		$display("checked %0d output beats over %0d seed writes", rx_beats, cfg_writes);
		$display("%0d of 9 patterns started, %0d mismatches", n_patterns, mismatches);
		if (mismatches == 0 && led_frames_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
